[rtl/core/wma2d_pkg.sv]
// Shared constants and types for the 2D weighted moving average block.
package wma2d_pkg;

  localparam int XY_W        = 24;
  localparam int WEIGHT_W    = 8;
  localparam int NUM_WEIGHTS = 8;
  localparam int WIDX_W      = $clog2(NUM_WEIGHTS);
  localparam int WINDOW_DEF  = 8;
  localparam int CFG_ADDR_W  = $clog2(NUM_WEIGHTS) + 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV_X,
    ST_DIV_Y,
    ST_DONE
  } state_t;

endpackage

[rtl/core/wma2d_div.sv]
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
module wma2d_div #(
  parameter int ACC_W = 35,
  parameter int SW_W  = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [ACC_W-1:0]            dividend,
  input  logic        [SW_W-1:0]             divisor,
  output logic                               done,
  output logic signed [wma2d_pkg::XY_W-1:0]  quotient
);
  import wma2d_pkg::*;

  localparam int STEP_W = $clog2(XY_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SW_W-1:0]   rem_r, rem_nxt;
  logic [XY_W-1:0]   q_r, q_nxt;
  logic [SW_W-1:0]   dvs_r;
  logic              neg_r;
  logic [ACC_W-1:0]  mag;
  logic [SW_W:0]     trial;
  logic [SW_W:0]     diff;
  logic              qbit;
  logic signed [XY_W-1:0] quo_r, quo_nxt;

  assign mag   = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
  assign trial = {rem_r, q_r[XY_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = SW_W'(mag >> XY_W);
      q_nxt    = mag[XY_W-1:0];
    end else if (busy_r) begin
      rem_nxt  = qbit ? diff[SW_W-1:0] : trial[SW_W-1:0];
      q_nxt    = {q_r[XY_W-2:0], qbit};
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(XY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        quo_nxt  = neg_r ? -$signed({q_r[XY_W-2:0], qbit})
                         : $signed({q_r[XY_W-2:0], qbit});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
      neg_r <= dividend[ACC_W-1];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still busy");

endmodule

[rtl/core/weighted_moving_average_2d_top.sv]
// Top level of the 2D weighted moving average filter.
//
// Usage: each input word carries one position sample (x, y) and a restart
// flag; restart empties the window before the sample is stored. The sample
// joins a window of the last WINDOW samples and one output word returns the
// weighted means of x and y over the samples in the window, oldest sample
// weighted by weight_0. When the weights in use sum to zero, both means are
// zero and weight_sum_zero is set.
// Weights are written through the APB port, one register per 4 bytes.
// From input accept to output valid, one multiplier walks the window slot by
// slot, x then y for each slot, one restoring divider then forms the x mean
// and the y mean in turn, and the output register is loaded. A zero weight
// sum skips the divider. A new word is taken only once the last one has
// reached the output register.
// in_tready is high only when no sample is in work; one result may wait in
// the output register while the next sample is taken, and a stalled receiver
// holds the block in its final state until the output register frees up.
// Reset empties the window and sets every weight to 1; history storage is
// not cleared.
module weighted_moving_average_2d_top #(
  parameter int WINDOW = wma2d_pkg::WINDOW_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // [23:0] pos_x, [47:24] pos_y
  input  logic [2*wma2d_pkg::XY_W-1:0]           in_tdata,
  // [0] restart
  input  logic                                   in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // [23:0] avg_x, [47:24] avg_y
  output logic [2*wma2d_pkg::XY_W-1:0]           out_tdata,
  // [0] weight_sum_zero
  output logic                                   out_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [wma2d_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [wma2d_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [wma2d_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                   cfg_pready
);
  import wma2d_pkg::*;

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ACC_W = 32 + $clog2(WINDOW);
  localparam int SW_W  = WEIGHT_W + $clog2(WINDOW);
  localparam int PRD_W = XY_W + WEIGHT_W + 1;

  // configuration
  logic [WEIGHT_W-1:0] weight_r [NUM_WEIGHTS];
  logic                cfg_wr;
  logic [WIDX_W-1:0]   cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = CFG_DATA_W'(weight_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_r[i] <= WEIGHT_RST;
      end
    end else if (cfg_wr) begin
      weight_r[cfg_idx] <= cfg_pwdata[WEIGHT_W-1:0];
    end
  end

  // control
  state_t            state_r, state_nxt;
  logic              in_acc;
  logic              mac_last;
  logic              div_start;
  logic              div_done;
  logic signed [ACC_W-1:0] div_dividend;
  logic signed [XY_W-1:0]  div_quo;
  logic              out_load;

  logic [CNT_W-1:0]  fill_r, fill_eff;
  logic [CNT_W-1:0]  cnt_r;
  logic              sel_y_r;
  logic [IDX_W-1:0]  idx;
  logic signed [XY_W-1:0] x_hist_r [WINDOW];
  logic signed [XY_W-1:0] y_hist_r [WINDOW];
  logic signed [XY_W-1:0] pos_x, pos_y;
  logic signed [XY_W-1:0] mul_a;
  logic [WEIGHT_W-1:0]    mul_w;
  logic signed [PRD_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;
  logic [SW_W-1:0]   sum_w_r;
  logic              zero_r;
  logic signed [XY_W-1:0] q_x_r, q_y_r;

  logic                   out_tvalid_r;
  logic [2*XY_W-1:0]      out_data_r;
  logic                   out_zero_r;

  assign pos_x    = in_tdata[XY_W-1:0];
  assign pos_y    = in_tdata[2*XY_W-1:XY_W];
  assign in_acc   = in_tvalid && in_tready;
  assign fill_eff = in_tuser ? '0 : fill_r;
  assign idx      = cnt_r[IDX_W-1:0];
  assign mac_last = sel_y_r && (cnt_r == fill_r - CNT_W'(1));
  assign out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  assign mul_a = sel_y_r ? y_hist_r[idx] : x_hist_r[idx];
  assign mul_w = weight_r[WIDX_W'(idx)];
  assign prod  = mul_a * $signed({1'b0, mul_w});

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = acc_x_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_last) begin
          if (sum_w_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV_X;
          end
        end
      end
      ST_DIV_X: begin
        div_dividend = acc_y_r;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_Y;
        end
      end
      ST_DIV_Y: begin
        div_dividend = acc_y_r;
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        fill_r <= (fill_eff < CNT_W'(WINDOW)) ? fill_eff + CNT_W'(1) : fill_eff;
      end
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // history: append while filling, shift out the oldest once full
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (fill_eff < CNT_W'(WINDOW)) begin
        x_hist_r[fill_eff[IDX_W-1:0]] <= pos_x;
        y_hist_r[fill_eff[IDX_W-1:0]] <= pos_y;
      end else begin
        for (int i = 0; i < WINDOW - 1; i++) begin
          x_hist_r[i] <= x_hist_r[i+1];
          y_hist_r[i] <= y_hist_r[i+1];
        end
        x_hist_r[WINDOW-1] <= pos_x;
        y_hist_r[WINDOW-1] <= pos_y;
      end
    end
  end

  // multiply-accumulate walk: x then y for each slot
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_r   <= '0;
      sel_y_r <= 1'b0;
      acc_x_r <= '0;
      acc_y_r <= '0;
      sum_w_r <= '0;
    end else if (state_r == ST_MAC) begin
      sel_y_r <= !sel_y_r;
      if (sel_y_r) begin
        cnt_r   <= cnt_r + CNT_W'(1);
        acc_y_r <= acc_y_r + ACC_W'(prod);
      end else begin
        acc_x_r <= acc_x_r + ACC_W'(prod);
        sum_w_r <= sum_w_r + SW_W'(mul_w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MAC && mac_last) begin
      zero_r <= (sum_w_r == '0);
      q_x_r  <= '0;
      q_y_r  <= '0;
    end else if (state_r == ST_DIV_X && div_done) begin
      q_x_r <= div_quo;
    end else if (state_r == ST_DIV_Y && div_done) begin
      q_y_r <= div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {q_y_r, q_x_r};
      out_zero_r <= zero_r;
    end
  end

  wma2d_div #(
    .ACC_W (ACC_W),
    .SW_W  (SW_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (sum_w_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_zero_r;

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW))
    else $error("window fill beyond window size");
  a_accept_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MAC) && (fill_r != '0))
    else $error("accepted word did not start the walk");
  a_zero_means: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("zero weight sum with nonzero means");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_X || state_r == ST_DIV_Y))
    else $error("divider result outside divide states");

endmodule
